[src/utf8d_pkg.sv]
// Shared types and codes for the UTF-8 byte stream decoder.
`timescale 1ns / 1ps
package utf8d_pkg;

	localparam int unsigned CP_W  = 31;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned ST_W  = 3;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_LEAD  = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_CONT  = 3'd2;
	localparam logic [ST_W-1:0] ST_TRUNCATED = 3'd3;
	localparam logic [ST_W-1:0] ST_END       = 3'd4;

	localparam logic [1:0] CONT_TAG = 2'b10;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
		logic [ST_W-1:0]  status;
	} result_t;

endpackage

[src/utf8_byte_stream_decoder_unit.sv]
// UTF-8 byte stream decoder (six-byte form) with a two-entry result buffer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per byte: in_byte, or
//   end_of_input high to mark end of stream. Output channel (out_valid /
//   out_stall) carries one beat per result: code_point, seq_length, status.
//   A lead or continuation byte that leaves a sequence open gives no beat;
//   a completed sequence, a bad lead, a bad continuation or an end marker
//   gives exactly one beat.
//   Throughput: one input beat per cycle while in_stall is low, set by the single
//   shift-and-mask update of the sequence registers.
//   Output: a result is registered into the result register, or into the skid
//   entry while the result register is held, when its input beat is taken.
//   Stall: a result register plus one skid entry part the two sides. The
//   input stalls only while the skid entry is full; it drains as soon as
//   the receiver takes the result register.
//   Reset: arst_n clears the sequence state to idle and empties both
//   result entries; the first byte after reset is taken as a lead byte.
`timescale 1ns / 1ps
module utf8_byte_stream_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_input,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [utf8d_pkg::CP_W-1:0]   code_point,
	output logic [utf8d_pkg::LEN_W-1:0]  seq_length,
	output logic [utf8d_pkg::ST_W-1:0]   status
);
	import utf8d_pkg::*;

	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] tot_q;
	logic [CP_W-1:0]  part_q;

	logic [LEN_W-1:0] rem_d;
	logic [LEN_W-1:0] tot_d;
	logic [CP_W-1:0]  part_d;
	logic [LEN_W-1:0] consumed;
	logic [CP_W-1:0]  part_cont;
	logic             has_res;
	result_t          res_d;

	result_t out_q;
	logic    out_valid_q;
	result_t skid_q;
	logic    skid_valid_q;

	logic in_take;
	logic out_take;

	assign in_stall  = skid_valid_q;
	assign in_take   = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;
	assign consumed  = tot_q - rem_q;
	assign part_cont = {part_q[CP_W-7:0], in_byte[5:0]};

	always_comb begin
		rem_d   = rem_q;
		tot_d   = tot_q;
		part_d  = part_q;
		has_res = 1'b0;
		res_d   = '{code_point: '0, seq_length: '0, status: ST_OK};
		if (end_of_input) begin
			has_res = 1'b1;
			rem_d   = '0;
			tot_d   = '0;
			part_d  = '0;
			if (rem_q != '0) begin
				res_d.seq_length = consumed;
				res_d.status     = ST_TRUNCATED;
			end else begin
				res_d.status = ST_END;
			end
		end else if (rem_q == '0) begin
			if (!in_byte[7]) begin
				has_res          = 1'b1;
				res_d.code_point = {{(CP_W-8){1'b0}}, in_byte};
				res_d.seq_length = 3'd1;
			end else if (!in_byte[6]) begin
				has_res          = 1'b1;
				res_d.seq_length = 3'd1;
				res_d.status     = ST_BAD_LEAD;
			end else if (!in_byte[5]) begin
				tot_d  = 3'd2;
				rem_d  = 3'd1;
				part_d = {{(CP_W-5){1'b0}}, in_byte[4:0]};
			end else if (!in_byte[4]) begin
				tot_d  = 3'd3;
				rem_d  = 3'd2;
				part_d = {{(CP_W-4){1'b0}}, in_byte[3:0]};
			end else if (!in_byte[3]) begin
				tot_d  = 3'd4;
				rem_d  = 3'd3;
				part_d = {{(CP_W-3){1'b0}}, in_byte[2:0]};
			end else if (!in_byte[2]) begin
				tot_d  = 3'd5;
				rem_d  = 3'd4;
				part_d = {{(CP_W-2){1'b0}}, in_byte[1:0]};
			end else begin
				tot_d  = 3'd6;
				rem_d  = 3'd5;
				part_d = {{(CP_W-1){1'b0}}, in_byte[0]};
			end
		end else if (in_byte[7:6] != CONT_TAG) begin
			has_res          = 1'b1;
			res_d.seq_length = consumed + 3'd1;
			res_d.status     = ST_BAD_CONT;
			rem_d            = '0;
			tot_d            = '0;
			part_d           = '0;
		end else if (rem_q == 3'd1) begin
			has_res          = 1'b1;
			res_d.code_point = part_cont;
			res_d.seq_length = tot_q;
			rem_d            = '0;
			tot_d            = '0;
			part_d           = '0;
		end else begin
			rem_d  = rem_q - 3'd1;
			part_d = part_cont;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			tot_q  <= '0;
			part_q <= '0;
		end else if (in_take) begin
			rem_q  <= rem_d;
			tot_q  <= tot_d;
			part_q <= part_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (in_take && has_res) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_take && has_res) begin
			if (!out_valid_q || out_take) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = out_q.code_point;
	assign seq_length = out_q.seq_length;
	assign status     = out_q.status;

`ifndef NO_ASSERTIONS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while result register empty");

	a_rem_below_tot: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> (rem_q < tot_q))
		else $error("remaining count not below sequence length");

	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |-> (out_q.code_point == '0))
		else $error("error result carries a code point");

	a_ok_has_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == ST_OK)) |-> (out_q.seq_length != '0))
		else $error("decoded result with zero length");

	a_end_drops_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && end_of_input) |=> (rem_q == '0 && tot_q == '0))
		else $error("sequence state not idle after end marker");
`endif

endmodule

[test/tb_utf8_byte_stream_decoder_unit.sv]
// Testbench for the UTF-8 byte stream decoder: directed and random byte streams, self-checked.
`timescale 1ns / 1ps
module tb_utf8_byte_stream_decoder_unit;
	import utf8d_pkg::*;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	logic [7:0]       in_byte      = 8'h00;
	logic             end_of_input = 1'b0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	logic [CP_W-1:0]  code_point;
	logic [LEN_W-1:0] seq_length;
	logic [ST_W-1:0]  status;

	result_t     pending_results[$];
	int unsigned error_count = 0;
	int unsigned bytes_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned gap_max     = 0;
	int unsigned stall_pct   = 0;
	int unsigned hold_cycles = 0;

	logic [2:0]      conts_left  = '0;
	logic [CP_W-1:0] partial_cp  = '0;
	logic [2:0]      lead_length = '0;

	utf8_byte_stream_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.seq_length   (seq_length),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else if (stall_pct == 0) begin
			out_stall <= 1'b0;
		end else if (out_stall) begin
			out_stall <= ($urandom_range(99) < stall_pct + 20);
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result cp=%h len=%0d status=%0d",
					$time, code_point, seq_length, status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (code_point !== want.code_point) begin
					$display("%0t: code_point expected %h actual %h",
						$time, want.code_point, code_point);
					error_count++;
				end
				if (seq_length !== want.seq_length) begin
					$display("%0t: seq_length expected %0d actual %0d",
						$time, want.seq_length, seq_length);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
					error_count++;
				end
			end
		end
	end

	task automatic clear_sequence();
		conts_left  = '0;
		partial_cp  = '0;
		lead_length = '0;
	endtask

	task automatic predict_decode(input logic [7:0] b, input logic eoi);
		result_t    r;
		logic       has_result;
		logic [2:0] n;
		logic [7:0] mask;
		r          = '0;
		has_result = 1'b1;
		n          = '0;
		mask       = '0;
		if (eoi) begin
			if (conts_left != 0) begin
				r.status     = ST_TRUNCATED;
				r.seq_length = lead_length - conts_left;
			end else begin
				r.status = ST_END;
			end
			clear_sequence();
		end else if (conts_left == 0) begin
			if ((b & 8'hfc) == 8'hfc) begin
				n    = 3'd6;
				mask = 8'h01;
			end else if ((b & 8'hf8) == 8'hf8) begin
				n    = 3'd5;
				mask = 8'h03;
			end else if ((b & 8'hf0) == 8'hf0) begin
				n    = 3'd4;
				mask = 8'h07;
			end else if ((b & 8'he0) == 8'he0) begin
				n    = 3'd3;
				mask = 8'h0f;
			end else if ((b & 8'hc0) == 8'hc0) begin
				n    = 3'd2;
				mask = 8'h1f;
			end else if (!b[7]) begin
				n    = 3'd1;
				mask = 8'hff;
			end
			if (n == 0) begin
				r.status     = ST_BAD_LEAD;
				r.seq_length = 3'd1;
			end else if (n == 1) begin
				r.status     = ST_OK;
				r.seq_length = 3'd1;
				r.code_point = CP_W'(b);
			end else begin
				partial_cp  = CP_W'(b & mask);
				lead_length = n;
				conts_left  = n - 3'd1;
				has_result  = 1'b0;
			end
		end else if (b[7:6] != CONT_TAG) begin
			r.status     = ST_BAD_CONT;
			r.seq_length = lead_length - conts_left + 3'd1;
			clear_sequence();
		end else begin
			partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
			conts_left = conts_left - 3'd1;
			if (conts_left == 0) begin
				r.status     = ST_OK;
				r.seq_length = lead_length;
				r.code_point = partial_cp;
				clear_sequence();
			end else begin
				has_result = 1'b0;
			end
		end
		if (has_result)
			pending_results.push_back(r);
	endtask

	task automatic send_beat(input logic [7:0] b, input logic eoi);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(gap_max, 0);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(24, 1);
		end
		in_valid     <= 1'b1;
		in_byte      <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_decode(b, eoi);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic send_sequence();
		int unsigned kind;
		int unsigned n;
		int unsigned bad_at;
		logic [7:0]  lead;
		logic [7:0]  junk;
		kind = $urandom_range(99);
		if (kind < 6) begin
			send_beat({CONT_TAG, 6'($urandom)}, 1'b0);
		end else if (kind < 9) begin
			send_beat(8'($urandom), 1'b1);
		end else if (kind < 12) begin
			send_beat(8'($urandom), 1'b0);
		end else begin
			n = $urandom_range(6, 1);
			case (n)
				1:       lead = {1'b0, 7'($urandom)};
				2:       lead = {3'b110, 5'($urandom)};
				3:       lead = {4'b1110, 4'($urandom)};
				4:       lead = {5'b11110, 3'($urandom)};
				5:       lead = {6'b111110, 2'($urandom)};
				default: lead = {6'b111111, 2'($urandom)};
			endcase
			bad_at = n;
			if (n > 1 && $urandom_range(99) < 15)
				bad_at = $urandom_range(n - 1, 1);
			send_beat(lead, 1'b0);
			for (int k = 1; k < n; k++) begin
				if (k == bad_at) begin
					junk = 8'($urandom);
					if ($urandom_range(1)) begin
						send_beat(junk, 1'b1);
					end else begin
						if (junk[7:6] == CONT_TAG)
							junk[7] = 1'b0;
						send_beat(junk, 1'b0);
					end
					break;
				end
				send_beat({CONT_TAG, 6'($urandom)}, 1'b0);
			end
		end
	endtask

	task automatic test_directed();
		logic [8:0] stream [24];
		stream = '{9'h000, 9'h07f, 9'h0df, 9'h0bf, 9'h0ef, 9'h0bf, 9'h0bf,
			9'h0f0, 9'h090, 9'h080, 9'h080,
			9'h0ff, 9'h0bf, 9'h0bf, 9'h0bf, 9'h0bf, 9'h0bf,
			9'h080, 9'h0c2, 9'h041, 9'h0f8, 9'h088, 9'h1a5, 9'h100};
		gap_max   = 0;
		stall_pct = 0;
		foreach (stream[i])
			send_beat(stream[i][7:0], stream[i][8]);
	endtask

	task automatic test_backpressure();
		gap_max     = 0;
		stall_pct   = 0;
		hold_cycles = 120;
		repeat (40)
			send_beat({1'b0, 7'($urandom)}, 1'b0);
	endtask

	task automatic test_random_stream();
		int unsigned target;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin gap_max = 0;  stall_pct = 0;  end
				1:       begin gap_max = 3;  stall_pct = 30; end
				2:       begin gap_max = 10; stall_pct = 55; end
				default: begin gap_max = 1;  stall_pct = 10; end
			endcase
			target = bytes_sent + 300;
			while (bytes_sent < target)
				send_sequence();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		pause_until_drained();
		test_backpressure();
		pause_until_drained();
		test_random_stream();
		pause_until_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
src/utf8d_pkg.sv
src/utf8_byte_stream_decoder_unit.sv
test/tb_utf8_byte_stream_decoder_unit.sv
